### design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int unsigned MAXF_BITS = 25;
  localparam logic [MAXF_BITS-1:0] MAXF_RESET = 25'd10485760;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_PAYLOAD  = 2'd0;
  localparam logic [1:0] STATUS_CLOSE    = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       last;
    logic [1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

### design/wsd_parser.sv
// Front end: header parser and unmasker, one byte per request.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser import wsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [MAXF_BITS-1:0] max_frame_bytes,
  input  wire logic                 in_valid,
  input  wire in_item_t             in_item,
  output logic                      res_valid,
  output out_item_t                 res
);

  localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT  = 6'b000100,
    PH_KEY  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  phase_t                phase, phase_next;
  logic [3:0]            ext_left, ext_left_next;
  logic                  fin_flag, fin_flag_next;
  logic [3:0]            cur_opcode, cur_opcode_next;
  logic                  mask_present, mask_present_next;
  logic [31:0]           mask_key, mask_key_next;
  logic [63:0]           declared_length, declared_length_next;
  logic [COUNT_BITS-1:0] payload_count, payload_count_next;

  logic [7:0]            b;
  logic [3:0]            op;
  logic                  len_done;
  logic [63:0]           len_final;
  logic [7:0]            key_byte;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  frame_last;

  always_comb begin
    b = in_item.data_byte;
    op = b[3:0];
    phase_next = phase;
    ext_left_next = ext_left;
    fin_flag_next = fin_flag;
    cur_opcode_next = cur_opcode;
    mask_present_next = mask_present;
    mask_key_next = mask_key;
    declared_length_next = declared_length;
    payload_count_next = payload_count;
    res_valid = 1'b0;
    res = '0;
    len_done = 1'b0;
    len_final = {declared_length[55:0], b};
    key_byte = '0;
    cnt_inc = payload_count + 1'b1;
    frame_last = 1'b0;

    if (in_valid) begin
      if (in_item.restart) begin
        phase_next = PH_HDR0;
        ext_left_next = '0;
        fin_flag_next = 1'b0;
        cur_opcode_next = '0;
        mask_present_next = 1'b0;
        mask_key_next = '0;
        declared_length_next = '0;
        payload_count_next = '0;
      end else begin
        case (phase)
          PH_HDR0: begin
            fin_flag_next = b[7];
            cur_opcode_next = op;
            if (b[6:4] != 3'b000 || !(op inside {OP_CONT, OP_TEXT, OP_BINARY,
                                                 OP_PING, OP_PONG})) begin
              res_valid = 1'b1;
              res.status = STATUS_CLOSE;
              res.last = 1'b1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_HDR1;
            end
          end
          PH_HDR1: begin
            mask_present_next = b[7];
            declared_length_next = '0;
            if (b[6:0] == LEN_EXT16) begin
              ext_left_next = 4'd2;
              phase_next = PH_EXT;
            end else if (b[6:0] == LEN_EXT64) begin
              ext_left_next = 4'd8;
              phase_next = PH_EXT;
            end else begin
              len_final = {57'd0, b[6:0]};
              len_done = 1'b1;
            end
          end
          PH_EXT: begin
            declared_length_next = len_final;
            ext_left_next = ext_left - 1'b1;
            len_done = (ext_left_next == 4'd0);
          end
          PH_KEY: begin
            mask_key_next = {mask_key[23:0], b};
            ext_left_next = ext_left - 1'b1;
            if (ext_left_next == 4'd0) begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            case (payload_count[1:0])
              2'd0: key_byte = mask_key[31:24];
              2'd1: key_byte = mask_key[23:16];
              2'd2: key_byte = mask_key[15:8];
              default: key_byte = mask_key[7:0];
            endcase
            frame_last = (64'(cnt_inc) == declared_length);
            res_valid = 1'b1;
            res.payload_byte = mask_present ? (b ^ key_byte) : b;
            res.frame_end = frame_last;
            res.last = frame_last && fin_flag;
            res.status = STATUS_PAYLOAD;
            payload_count_next = frame_last ? '0 : cnt_inc;
            if (frame_last) begin
              phase_next = fin_flag ? PH_DONE : PH_HDR0;
            end
          end
          PH_DONE: begin
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase

        if (len_done) begin
          declared_length_next = len_final;
          if (len_final == 64'd0) begin
            res_valid = 1'b1;
            res.status = STATUS_CLOSE;
            res.last = 1'b1;
            phase_next = PH_DONE;
          end else if (len_final > {{(64-MAXF_BITS){1'b0}}, max_frame_bytes} ||
                       len_final > COUNT_MAX) begin
            res_valid = 1'b1;
            res.status = STATUS_TOO_BIG;
            res.last = 1'b1;
            phase_next = PH_DONE;
          end else begin
            payload_count_next = '0;
            if (mask_present_next) begin
              ext_left_next = 4'd4;
              phase_next = PH_KEY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
    end
    res.frame_opcode = cur_opcode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      ext_left <= '0;
      fin_flag <= 1'b0;
      cur_opcode <= '0;
      mask_present <= 1'b0;
      mask_key <= '0;
      declared_length <= '0;
      payload_count <= '0;
    end else begin
      phase <= phase_next;
      ext_left <= ext_left_next;
      fin_flag <= fin_flag_next;
      cur_opcode <= cur_opcode_next;
      mask_present <= mask_present_next;
      mask_key <= mask_key_next;
      declared_length <= declared_length_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

### design/wsd_queue.sv
// Back end: short result queue between the parser and the output ports.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue import wsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire out_item_t wr_data,
  input  wire logic      rd_en,
  output out_item_t      rd_data,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  out_item_t            mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_wr, do_rd;

  assign full = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one stream byte per cycle (push/full) and
// returns unmasked payload bytes and close/error marks (pop/empty). Every
// accepted byte is parsed in the cycle it arrives; header bytes give no result,
// payload bytes and rejected frames give one. Sustained rate is one byte per
// clock while the result queue has room; a two-entry result queue lets the
// output side stall without stopping input until it fills. max_frame_bytes is
// written through cfg_wr_en/cfg_wr_data and resets to 10485760.
// Depends on wsd_pkg, wsd_parser, wsd_queue.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 result,
  input  wire logic                 cfg_wr_en,
  input  wire logic [MAXF_BITS-1:0] cfg_wr_data
);

  logic [MAXF_BITS-1:0] max_frame_bytes;
  logic                 accept;
  logic                 res_valid;
  out_item_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAXF_RESET;
    end else if (cfg_wr_en) begin
      max_frame_bytes <= cfg_wr_data;
    end
  end

  assign accept = push && !full;

  wsd_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .max_frame_bytes(max_frame_bytes),
    .in_valid       (accept),
    .in_item        (item),
    .res_valid      (res_valid),
    .res            (res)
  );

  wsd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_valid),
    .wr_data(res),
    .rd_en  (pop),
    .rd_data(result),
    .full   (full),
    .empty  (empty)
  );

endmodule

`default_nettype wire

### design/wsd_checker.sv
// Port-level checks for websocket_frame_deframer, bound to the top level.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker import wsd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t result
);

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("queue not empty after reset");

  a_pop_frees_space: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> !full)
    else $error("full after a popped request");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != STATUS_PAYLOAD) |->
      (result.last && !result.frame_end && result.payload_byte == 8'd0 &&
       (result.status == STATUS_CLOSE || result.status == STATUS_TOO_BIG)))
    else $error("malformed error result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);

`default_nettype wire

### tb/tb.sv
// Testbench for websocket_frame_deframer: directed and random byte streams, with a
// scoreboard that tracks the frame parser and checks every popped result.
// Depends on wsd_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam logic [63:0] COUNT_MAX = 64'h1FFFFFF;

  class deframe_mirror;
    typedef enum int {HDR0, HDR1, EXTLEN, KEY, BODY, DONE} stage_e;

    logic [MAXF_BITS-1:0] max_bytes;
    stage_e stage;
    int ext_left;
    bit fin;
    logic [3:0] opcode;
    bit masked;
    logic [31:0] key;
    logic [63:0] frame_len;
    logic [24:0] count;
    out_item_t due_out[$];
    int mismatches;
    int n_body;
    int n_close;
    int n_oversize;

    function new();
      max_bytes = MAXF_RESET;
      clear();
    endfunction

    function void clear();
      stage = HDR0;
      ext_left = 0;
      fin = 0;
      opcode = '0;
      masked = 0;
      key = '0;
      frame_len = '0;
      count = '0;
    endfunction

    function void abort(logic [1:0] code);
      out_item_t e;
      e.payload_byte = '0;
      e.frame_opcode = opcode;
      e.frame_end = 1'b0;
      e.last = 1'b1;
      e.status = code;
      due_out = {due_out, e};
      stage = DONE;
    endfunction

    function void length_done();
      if (frame_len == 0) begin
        abort(STATUS_CLOSE);
      end else if (frame_len > 64'(max_bytes) || frame_len > COUNT_MAX) begin
        abort(STATUS_TOO_BIG);
      end else begin
        count = '0;
        if (masked) begin
          ext_left = 4;
          stage = KEY;
        end else begin
          stage = BODY;
        end
      end
    endfunction

    // one accepted request
    function void take_byte(in_item_t it);
      logic [7:0] b;
      logic [7:0] kb;
      out_item_t e;
      b = it.data_byte;
      if (it.restart) begin
        clear();
        return;
      end
      case (stage)
        HDR0: begin
          fin = b[7];
          opcode = b[3:0];
          if (b[6:4] != 3'b000 ||
              !(opcode inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG})) begin
            abort(STATUS_CLOSE);
          end else begin
            stage = HDR1;
          end
        end
        HDR1: begin
          masked = b[7];
          frame_len = '0;
          if (b[6:0] == LEN_EXT16) begin
            ext_left = 2;
            stage = EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_left = 8;
            stage = EXTLEN;
          end else begin
            frame_len = 64'(b[6:0]);
            length_done();
          end
        end
        EXTLEN: begin
          frame_len = {frame_len[55:0], b};
          ext_left--;
          if (ext_left == 0) length_done();
        end
        KEY: begin
          key = {key[23:0], b};
          ext_left--;
          if (ext_left == 0) stage = BODY;
        end
        BODY: begin
          kb = key[8 * (3 - int'(count[1:0])) +: 8];
          e.payload_byte = masked ? (b ^ kb) : b;
          count = count + 25'd1;
          e.frame_opcode = opcode;
          e.frame_end = (64'(count) == frame_len);
          e.last = e.frame_end && fin;
          e.status = STATUS_PAYLOAD;
          due_out = {due_out, e};
          if (e.frame_end) begin
            count = '0;
            stage = fin ? DONE : HDR0;
          end
        end
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_output(out_item_t got);
      out_item_t want;
      bit ok;
      if (due_out.size() == 0) begin
        $display({"%0t: result with none expected: expected nothing, ",
                  "got byte %0h op %0h end %0b last %0b status %0d"},
                 $time, got.payload_byte, got.frame_opcode, got.frame_end, got.last,
                 got.status);
        mismatches++;
        return;
      end
      want = due_out.pop_front();
      ok = 1'b1;
      ok &= field_ok("payload_byte", want.payload_byte, got.payload_byte);
      ok &= field_ok("frame_opcode", 8'(want.frame_opcode), 8'(got.frame_opcode));
      ok &= field_ok("frame_end", 8'(want.frame_end), 8'(got.frame_end));
      ok &= field_ok("last", 8'(want.last), 8'(got.last));
      ok &= field_ok("status", 8'(want.status), 8'(got.status));
      if (!ok) mismatches++;
      case (want.status)
        STATUS_CLOSE:  n_close++;
        STATUS_TOO_BIG: n_oversize++;
        default:       n_body++;
      endcase
    endfunction

    function int pending();
      return due_out.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_wr_en = 1'b0;
  logic [MAXF_BITS-1:0] cfg_wr_data = '0;

  deframe_mirror mirror;
  bit rx_on = 1'b0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  int rx_wait = 0;
  int n_sent = 0;
  int n_counted = 0;
  int n_limits = 0;

  websocket_frame_deframer u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_on) begin
      if (pop && !empty) begin
        mirror.match_output(result);
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
        if (rx_wait != 0) pop <= 1'b0;
      end else if (!pop) begin
        if (rx_wait == 0) pop <= 1'b1;
        else rx_wait--;
      end
    end
  end

  function automatic in_item_t stream_req(logic r, logic [7:0] b);
    in_item_t it;
    it.restart = r;
    it.data_byte = b;
    return it;
  endfunction

  function automatic bit frame_fits(logic [63:0] len);
    return len != 0 && len <= 64'(mirror.max_bytes) && len <= COUNT_MAX;
  endfunction

  function automatic logic [3:0] any_good_op();
    case ($urandom_range(0, 4))
      0: return OP_CONT;
      1: return OP_TEXT;
      2: return OP_BINARY;
      3: return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  function automatic void add_header(ref in_item_t q[$], input bit fin, input logic [3:0] op,
                                     input bit masked, input logic [63:0] len,
                                     input int form);
    q = {q, stream_req(1'b0, {fin, 3'b000, op})};
    case (form)
      0: q = {q, stream_req(1'b0, {masked, len[6:0]})};
      1: begin
        q = {q, stream_req(1'b0, {masked, LEN_EXT16})};
        q = {q, stream_req(1'b0, len[15:8])};
        q = {q, stream_req(1'b0, len[7:0])};
      end
      default: begin
        q = {q, stream_req(1'b0, {masked, LEN_EXT64})};
        for (int i = 7; i >= 0; i--) q = {q, stream_req(1'b0, len[8 * i +: 8])};
      end
    endcase
  endfunction

  function automatic void add_body(ref in_item_t q[$], input bit masked, input int n);
    if (masked) for (int i = 0; i < 4; i++) q = {q, stream_req(1'b0, 8'($urandom))};
    for (int i = 0; i < n; i++) q = {q, stream_req(1'b0, 8'($urandom))};
  endfunction

  task automatic push_item(in_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    mirror.take_byte(it);
    n_sent++;
  endtask

  task automatic push_list(in_item_t q[$]);
    foreach (q[i]) push_item(q[i]);
  endtask

  // sender holds off until every expected result is out, then lets the result queue settle
  task automatic settle();
    push <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [MAXF_BITS-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.max_bytes = v;
    n_limits++;
  endtask

  task automatic random_message();
    in_item_t q[$];
    int kind;
    int nfr;
    int form;
    int r;
    bit fin;
    bit masked;
    bit ended;
    logic [3:0] op;
    logic [63:0] len;
    q = {q, stream_req(1'b1, 8'($urandom))};
    kind = $urandom_range(0, 99);
    ended = 1'b0;
    if (kind < 75) nfr = $urandom_range(1, 3);
    else if (kind < 90) nfr = $urandom_range(0, 1);
    else nfr = 0;
    for (int i = 0; i < nfr && !ended; i++) begin
      fin = (kind < 75) && (i == nfr - 1);
      if (i == 0) op = any_good_op();
      else op = ($urandom_range(0, 3) == 0) ? any_good_op() : OP_CONT;
      masked = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        form = 0;
        len = $urandom_range(1, 12);
      end else if (r < 70) begin
        form = 0;
        len = $urandom_range(100, 125);
      end else if (r < 82) begin
        form = 1;
        len = $urandom_range(1, 40);
      end else if (r < 85) begin
        form = 1;
        len = $urandom_range(126, 300);
      end else begin
        form = 2;
        len = $urandom_range(1, 20);
      end
      add_header(q, fin, op, masked, len, form);
      if (frame_fits(len)) add_body(q, masked, int'(len));
      else ended = 1'b1;
    end
    if (kind >= 75 && kind < 90 && !ended) begin
      case ($urandom_range(0, 3))
        0: q = {q, stream_req(1'b0, {1'($urandom), 3'($urandom_range(1, 7)),
                                     any_good_op()})};
        1: begin
          do op = 4'($urandom);
          while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG});
          q = {q, stream_req(1'b0, {1'($urandom), 3'($urandom), op})};
        end
        2: add_header(q, $urandom_range(0, 1), any_good_op(), $urandom_range(0, 1), '0,
                      $urandom_range(0, 2));
        default: begin
          case ($urandom_range(0, 2))
            0: len = 64'(mirror.max_bytes) + 64'd1;
            1: len = COUNT_MAX + 64'd1;
            default: len = {1'b1, 31'($urandom), 32'($urandom)};
          endcase
          if (len < 126) form = $urandom_range(0, 2);
          else if (len < 65536) form = $urandom_range(1, 2);
          else form = 2;
          add_header(q, $urandom_range(0, 1), any_good_op(), $urandom_range(0, 1), len,
                     form);
        end
      endcase
    end else if (kind >= 90) begin
      repeat ($urandom_range(3, 20)) q = {q, stream_req(1'b0, 8'($urandom))};
    end
    if ($urandom_range(0, 11) == 0 && q.size() > 2) q = q[0:$urandom_range(1, q.size() - 2)];
    n_counted += q.size();
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) q = {q, stream_req(1'b0, 8'($urandom))};
    if ($urandom_range(0, 4) == 0) tx_calm = !tx_calm;
    push_list(q);
  endtask

  task automatic run_phase(int target);
    int start;
    start = n_counted;
    while (n_counted - start < target) random_message();
  endtask

  initial begin
    in_item_t dq[$];
    mirror = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    rx_on <= 1'b1;

    // ping fragment, masked fin pong, ignored byte, reserved bits, 64-bit oversize
    dq = '{stream_req(1'b1, 8'h00),
           stream_req(1'b0, 8'h09), stream_req(1'b0, 8'h01), stream_req(1'b0, 8'h00),
           stream_req(1'b0, 8'h8A), stream_req(1'b0, 8'h81),
           stream_req(1'b0, 8'hFF), stream_req(1'b0, 8'h00), stream_req(1'b0, 8'hAA),
           stream_req(1'b0, 8'h55), stream_req(1'b0, 8'hFF),
           stream_req(1'b0, 8'h55),
           stream_req(1'b1, 8'hFF), stream_req(1'b0, 8'hF1),
           stream_req(1'b1, 8'h00), stream_req(1'b0, 8'h02), stream_req(1'b0, 8'hFF)};
    repeat (8) dq = {dq, stream_req(1'b0, 8'hFF)};
    push_list(dq);

    run_phase(300);
    set_limit(25'd1);
    run_phase(60);
    set_limit(25'd0);
    run_phase(40);
    set_limit(25'd16777216);
    run_phase(250);
    set_limit(25'h1FFFFFF);
    run_phase(200);
    set_limit(25'($urandom_range(2, 40)));
    run_phase(200);

    settle();
    repeat (8) @(posedge clk);
    $display("tb: %0d requests sent, %0d payload bytes, %0d closes, %0d oversize frames",
             n_sent, mirror.n_body, mirror.n_close, mirror.n_oversize);
    $display("tb: %0d frame size limits written (0, 1, 2^24, 2^25-1, small)", n_limits);
    if (mirror.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
design/wsd_pkg.sv
design/wsd_parser.sv
design/wsd_queue.sv
design/websocket_frame_deframer.sv
design/wsd_checker.sv
tb/tb.sv
